// ===== hdl/binary_to_decimal_ascii_defines.svh =====
// Assertion macros shared by the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/b2da_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 10;
    localparam int NUM_DIGITS_DEF  = (VALUE_WIDTH_DEF * 30103) / 100000 + 1;

    localparam int RADIX = 10;

    localparam logic [5:0] CHAR_ZERO    = 6'd48;
    localparam logic [3:0] DABBLE_LIMIT = 4'(RADIX / 2);
    localparam logic [3:0] DABBLE_ADD   = 4'((16 - RADIX) / 2);

    typedef struct packed {
        logic load;
        logic shift_digit;
    } b2da_ctrl_t;

    typedef struct packed {
        logic busy;
    } b2da_status_t;

endpackage

// ===== hdl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
//
//  channel | fields                  | handshake
//  --------+-------------------------+--------------------------
//  value   | value                   | value_valid / value_ready
//  digit   | digit_char, last_digit  | digit_valid / digit_ready
//
// A number passes through the one-bit-per-cycle BCD shift and then the digit scan.
// The scan spends one cycle per digit position while the output is not stalled,
// leading zeros included.
// Reset clears the control state; nothing is kept between numbers.
// A stalled digit beat holds the scan; a new number is taken while the last digit waits.
module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   value_valid,
    output logic                   value_ready,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   digit_valid,
    input  logic                   digit_ready,
    output logic [5:0]             digit_char,
    output logic                   last_digit
);
    import b2da_pkg::*;
    `include "binary_to_decimal_ascii_defines.svh"

    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int POS_W      = $clog2(NUM_DIGITS);
    localparam int CMP_W      = $clog2(NUM_DIGITS + MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic         seen_reg, seen_next;
    logic         valid_reg, valid_next;
    logic [5:0]   char_reg, char_next;
    logic         last_reg, last_next;

    b2da_ctrl_t   ctrl;
    b2da_status_t status;
    logic [3:0]   top_digit;
    logic         advance;
    logic         emit;

    b2da_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .value     (value),
        .status    (status),
        .top_digit (top_digit)
    );

    assign value_ready = (state_reg == ST_IDLE);
    assign advance     = !valid_reg || digit_ready;
    assign emit        = (CMP_W'(pos_reg) < CMP_W'(MAX_DIGITS))
                         && (seen_reg || (top_digit != 4'd0) || (pos_reg == '0));

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        seen_next        = seen_reg;
        valid_next       = valid_reg && !digit_ready;
        char_next        = char_reg;
        last_next        = last_reg;
        ctrl.load        = 1'b0;
        ctrl.shift_digit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (!status.busy)
                begin
                    pos_next   = POS_W'(NUM_DIGITS - 1);
                    seen_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    valid_next       = emit;
                    ctrl.shift_digit = 1'b1;
                    seen_next        = seen_reg || (top_digit != 4'd0);
                    if (emit)
                    begin
                        char_next = CHAR_ZERO + {2'b00, top_digit};
                        last_next = (pos_reg == '0);
                    end
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign digit_valid = valid_reg;
    assign digit_char  = char_reg;
    assign last_digit  = last_reg;

    `B2DA_ASSERT_NEXT(a_load_starts, clk, rst_n, value_valid && value_ready, status.busy, "converter did not start on an accepted beat")
    `B2DA_ASSERT_NOW(a_scan_after_conv, clk, rst_n, state_reg == ST_SCAN, !status.busy, "digit scan overlaps the conversion")
    `B2DA_ASSERT_NEXT(a_last_marked, clk, rst_n, (state_reg == ST_SCAN) && (pos_reg == '0) && advance, (state_reg == ST_IDLE) && valid_reg && last_reg, "final digit not emitted with its mark")

endmodule

// ===== hdl/b2da_dabble.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per cycle; shift_digit then moves the digits up to top_digit.
module b2da_dabble #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = b2da_pkg::NUM_DIGITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  b2da_pkg::b2da_ctrl_t     ctrl,
    input  logic [VALUE_WIDTH-1:0]   value,
    output b2da_pkg::b2da_status_t   status,
    output logic [3:0]               top_digit
);
    import b2da_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= DABBLE_LIMIT)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + DABBLE_ADD;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.load)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (ctrl.shift_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign top_digit   = bcd_reg[BCD_W-1 -: 4];

endmodule
